// ===== src/vis_pkg.sv =====
// Package for the virtual interrupt state unit: operation codes, register
// indexes, field widths and the packed beat types of both channels.
// No dependencies.
package vis_pkg;

  localparam int NUM_IDS_DEF = 64;
  localparam int ID_W        = 10;
  localparam int VM_W        = 16;
  localparam int VCPU_W      = 7;
  localparam int CNT_W       = 11;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_INJECT  = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_ACK     = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_VM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCPU_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_VM = 2'd2;

  typedef struct packed {
    op_t              operation;
    logic [ID_W-1:0]  intr_id;
    logic             fiq_kind;
    logic [VM_W-1:0]  caller_vm_id;
    logic             caller_is_target;
    logic [VM_W-1:0]  dest_vm_id;
    logic [VM_W-1:0]  dest_vcpu_index;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic             kick_primary;
    logic             wake_target;
    logic [ID_W-1:0]  ack_id;
    logic             ack_valid;
    logic [CNT_W-1:0] irq_pending_count;
    logic [CNT_W-1:0] fiq_pending_count;
  } out_item_t;

  typedef struct packed {
    logic [VM_W-1:0]   own_vm_id;
    logic [VCPU_W-1:0] vcpu_limit;
    logic [VM_W-1:0]   primary_vm_id;
  } cfg_t;

endpackage

// ===== src/virtual_interrupt_state_unit.sv =====
// Top level of the virtual interrupt state unit: input and result registers,
// configuration registers and the vis_core state block. Depends on vis_pkg.
//
//   channel | ports                                | beat
//   --------+--------------------------------------+-------------------------
//   input   | in_valid, in_stall, in_data          | one in_item_t operation
//   result  | out_valid, out_stall, out_data       | one out_item_t per beat
//   config  | cfg_we, cfg_index, cfg_data          | one register write
//
// One beat in and one beat out per cycle unless the result stalls; each
// beat passes the input and result registers, the bitmap update done
// in one pass between them. Reset is synchronous on rst_n: bitmaps and
// tallies clear, configuration returns to 1, 1, 1. A stalled result holds
// the result register; the input register then holds and in_stall rises.
module virtual_interrupt_state_unit
  import vis_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  cfg_t      cfg_r;
  out_item_t result;
  logic      advance;
  logic      fire;

  // The result register can take a new beat when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Input register: load whenever it is not held by a stalled result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Result register: advance with the update, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  // Configuration registers; writes are to arrive only while the unit is idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_vm_id     <= VM_W'(1);
      cfg_r.vcpu_limit    <= VCPU_W'(1);
      cfg_r.primary_vm_id <= VM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_VM:     cfg_r.own_vm_id     <= cfg_data[VM_W-1:0];
        CFG_VCPU_LIMIT: cfg_r.vcpu_limit    <= cfg_data[VCPU_W-1:0];
        CFG_PRIMARY_VM: cfg_r.primary_vm_id <= cfg_data[VM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  vis_core #(.NUM_IDS(NUM_IDS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // A stalled result is never dropped
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result lost");

  // Kick and wake are exclusive
  a_kick_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.kick_primary && out_data.wake_target))
    else $error("kick and wake both set");

  // An acknowledge never reports a rejection or a kick
  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ack_valid |->
      !out_data.status && !out_data.kick_primary && !out_data.wake_target)
    else $error("acknowledge result mixed with inject flags");

  // Tallies stay within the id range
  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.irq_pending_count <= CNT_W'(NUM_IDS)) &&
                  (out_data.fiq_pending_count <= CNT_W'(NUM_IDS)))
    else $error("pending tally beyond id range");

  // The input register holds while the result side is stalled
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |=> in_valid_r && $stable(in_item_r))
    else $error("input beat changed while held");

endmodule

// ===== src/vis_ffs.sv =====
// Lowest-set-bit finder over the enabled-and-pending bitmap.
// Depends on nothing; width follows the N parameter.
module vis_ffs #(
  parameter int N     = 64,
  parameter int IDX_W = $clog2(N)
) (
  input  logic [N-1:0]     vec,
  output logic [N-1:0]     onehot,
  output logic [IDX_W-1:0] idx,
  output logic             found
);

  // Isolate the lowest set bit with one wide add, then encode it
  assign onehot = vec & (~vec + N'(1));
  assign found  = |vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

// ===== src/vis_core.sv =====
// Bitmap and tally state of one vCPU with its single-pass update logic.
// Depends on vis_pkg and vis_ffs.
module vis_core
  import vis_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int IDX_W = $clog2(NUM_IDS);
  localparam int TW    = $clog2(NUM_IDS + 1);

  logic [NUM_IDS-1:0] enabled_r, enabled_nxt;
  logic [NUM_IDS-1:0] pending_r, pending_nxt;
  logic [NUM_IDS-1:0] fiq_type_r, fiq_type_nxt;
  logic [TW-1:0]      irq_tally_r, irq_tally_nxt;
  logic [TW-1:0]      fiq_tally_r, fiq_tally_nxt;

  logic [NUM_IDS-1:0] mask;
  logic               in_range;
  logic               hit_en, hit_pend, hit_fiq;
  logic               reject;
  logic [TW:0]        total;
  logic [NUM_IDS-1:0] ack_onehot;
  logic [IDX_W-1:0]   ack_idx;
  logic               ack_found;

  function automatic logic [TW-1:0] tally_inc(input logic [TW-1:0] t);
    return (t != TW'(NUM_IDS)) ? t + TW'(1) : t;
  endfunction

  function automatic logic [TW-1:0] tally_dec(input logic [TW-1:0] t);
    return (t != '0) ? t - TW'(1) : t;
  endfunction

  vis_ffs #(.N(NUM_IDS), .IDX_W(IDX_W)) u_ffs (
    .vec    (enabled_r & pending_r),
    .onehot (ack_onehot),
    .idx    (ack_idx),
    .found  (ack_found)
  );

  assign mask     = NUM_IDS'(1) << item.intr_id[IDX_W-1:0];
  assign in_range = {1'b0, item.intr_id} < (ID_W + 1)'(NUM_IDS);
  assign hit_en   = |(enabled_r & mask);
  assign hit_pend = |(pending_r & mask);
  assign hit_fiq  = |(fiq_type_r & mask);
  assign reject   = !in_range || (item.dest_vm_id != cfg.own_vm_id) ||
                    (item.dest_vcpu_index >= VM_W'(cfg.vcpu_limit)) ||
                    ((item.caller_vm_id != cfg.primary_vm_id) &&
                     (item.caller_vm_id != item.dest_vm_id));

  always_comb begin
    enabled_nxt   = enabled_r;
    pending_nxt   = pending_r;
    fiq_type_nxt  = fiq_type_r;
    irq_tally_nxt = irq_tally_r;
    fiq_tally_nxt = fiq_tally_r;
    total         = '0;
    result        = '0;
    unique case (item.operation)
      OP_INJECT: begin
        if (reject) begin
          result.status = 1'b1;
        end else begin
          if (hit_en && !hit_pend) begin
            if (hit_fiq) begin
              fiq_tally_nxt = tally_inc(fiq_tally_r);
            end else begin
              irq_tally_nxt = tally_inc(irq_tally_r);
            end
            total = {1'b0, irq_tally_nxt} + {1'b0, fiq_tally_nxt};
            // first enabled pending interrupt: get the target running
            if (total == (TW + 1)'(1)) begin
              if (item.caller_vm_id == cfg.primary_vm_id) begin
                result.kick_primary = 1'b1;
              end else if (!item.caller_is_target) begin
                result.wake_target = 1'b1;
              end
            end
          end
          pending_nxt = pending_r | mask;
        end
      end
      OP_ENABLE: begin
        if (!in_range) begin
          result.status = 1'b1;
        end else begin
          if (hit_pend && !hit_en) begin
            if (hit_fiq) begin
              fiq_tally_nxt = tally_inc(fiq_tally_r);
            end else begin
              irq_tally_nxt = tally_inc(irq_tally_r);
            end
          end
          enabled_nxt  = enabled_r | mask;
          fiq_type_nxt = item.fiq_kind ? (fiq_type_r | mask) : (fiq_type_r & ~mask);
        end
      end
      OP_DISABLE: begin
        if (!in_range) begin
          result.status = 1'b1;
        end else begin
          if (hit_pend && hit_en) begin
            if (hit_fiq) begin
              fiq_tally_nxt = tally_dec(fiq_tally_r);
            end else begin
              irq_tally_nxt = tally_dec(irq_tally_r);
            end
          end
          enabled_nxt  = enabled_r & ~mask;
          fiq_type_nxt = fiq_type_r & ~mask;
        end
      end
      OP_ACK: begin
        if (ack_found) begin
          pending_nxt = pending_r & ~ack_onehot;
          if (|(fiq_type_r & ack_onehot)) begin
            fiq_tally_nxt = tally_dec(fiq_tally_r);
          end else begin
            irq_tally_nxt = tally_dec(irq_tally_r);
          end
          result.ack_id    = ID_W'(ack_idx);
          result.ack_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    result.irq_pending_count = CNT_W'(irq_tally_nxt);
    result.fiq_pending_count = CNT_W'(fiq_tally_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= '0;
      pending_r   <= '0;
      fiq_type_r  <= '0;
      irq_tally_r <= '0;
      fiq_tally_r <= '0;
    end else if (fire) begin
      enabled_r   <= enabled_nxt;
      pending_r   <= pending_nxt;
      fiq_type_r  <= fiq_type_nxt;
      irq_tally_r <= irq_tally_nxt;
      fiq_tally_r <= fiq_tally_nxt;
    end
  end

endmodule
